@@ hw/rtl/lru_tag_table_with_pins_macros.svh @@
// Assertion macros for the tag table checker.
// No dependencies; included by the checker file only.
`ifndef LRU_TAG_TABLE_WITH_PINS_MACROS_SVH
`define LRU_TAG_TABLE_WITH_PINS_MACROS_SVH

// same-cycle implication
`define LTT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ltt_pkg.sv @@
// Package for the LRU tag table: codes, types and default constants.
// No dependencies; used by the controller, datapath, top level and checker.
package ltt_pkg;

  localparam int ENTRIES_DEF = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] K_PUT_ART   = 4'd0;
  localparam logic [3:0] K_PUT_NOART = 4'd1;
  localparam logic [3:0] K_PUT_TAGS  = 4'd2;
  localparam logic [3:0] K_PUT_WALK  = 4'd3;
  localparam logic [3:0] K_GET_ART   = 4'd4;
  localparam logic [3:0] K_GET_TAGS  = 4'd5;
  localparam logic [3:0] K_GET_WALK  = 4'd6;
  localparam logic [3:0] K_Q_NOART   = 4'd7;
  localparam logic [3:0] K_GET_AKEY  = 4'd8;
  localparam logic [3:0] K_PIN       = 4'd9;
  localparam logic [3:0] K_UNPIN_ALL = 4'd10;
  localparam logic [3:0] K_CLEAR     = 4'd11;
  localparam logic [3:0] K_STATS     = 4'd12;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_NC   = 2'd2;
  localparam logic [1:0] ST_IGN  = 2'd3;

  localparam logic CFG_TAG  = 1'b0;
  localparam logic CFG_WALK = 1'b1;

  localparam int FL_NOART = 0;
  localparam int FL_TAGS  = 1;
  localparam int FL_WALK  = 2;

  localparam logic [29:0] SAT30 = 30'h3FFFFFFF;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_SCAN2, S_APPLY, S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] art_key_out;
    logic [23:0] art_len_out;
    logic        shared;
    logic        freed_valid;
    logic [31:0] freed_key;
    logic [4:0]  entry_count;
    logic [29:0] bytes_held;
    logic [29:0] bytes_saved;
  } res_t;

endpackage

@@ hw/rtl/ltt_if.sv @@
// Handshake channel interfaces for requests and responses.
// Depends on nothing; used by the top level.
interface ltt_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] path_key;
  logic [31:0] content_key;
  logic [23:0] content_len;
  modport source (output valid, kind, path_key, content_key, content_len, input ready);
  modport sink (input valid, kind, path_key, content_key, content_len, output ready);
endinterface

interface ltt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic        evicted;
  logic [31:0] art_key_out;
  logic [23:0] art_len_out;
  logic        shared;
  logic        freed_valid;
  logic [31:0] freed_key;
  logic [4:0]  entry_count;
  logic [29:0] bytes_held;
  logic [29:0] bytes_saved;
  modport source (output valid, status, slot, evicted, art_key_out, art_len_out, shared,
                  freed_valid, freed_key, entry_count, bytes_held, bytes_saved,
                  input ready);
  modport sink (input valid, status, slot, evicted, art_key_out, art_len_out, shared,
                freed_valid, freed_key, entry_count, bytes_held, bytes_saved,
                output ready);
endinterface

@@ hw/rtl/ltt_ctrl.sv @@
// Sequencer for the tag table: two scans over the entries, apply, respond.
// Depends on ltt_pkg.
module ltt_ctrl import ltt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN1;
      S_SCAN1: if (sts.last) state_next = S_SCAN2;
      S_SCAN2: if (sts.last) state_next = S_APPLY;
      S_APPLY: state_next = S_RESP;
      S_RESP:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN1: cmd.step1 = 1'b1;
      S_SCAN2: cmd.step2 = 1'b1;
      S_APPLY: cmd.apply = 1'b1;
      S_RESP:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/ltt_dp.sv @@
// Datapath for the tag table: entry registers, scan accumulators, result register.
// Depends on ltt_pkg.
module ltt_dp import ltt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [3:0]            kind,
  input  logic [31:0]           path_key,
  input  logic [31:0]           content_key,
  input  logic [23:0]           content_len,
  output res_t                  res
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [11:0] tag_bytes;
  logic [15:0] walk_bytes;

  logic        used      [ENTRIES];
  logic        pinned    [ENTRIES];
  logic [31:0] stamp     [ENTRIES];
  logic [31:0] ekey      [ENTRIES];
  logic        art_valid [ENTRIES];
  logic [31:0] art_key   [ENTRIES];
  logic [23:0] art_len   [ENTRIES];
  logic [2:0]  flags     [ENTRIES];
  logic [31:0] use_clock;

  logic [3:0]  kind_q;
  logic [31:0] pkey_q;
  logic [31:0] ckey_q;
  logic [23:0] clen_q;

  logic [IW-1:0] idx;
  logic          m_found, f_found, v_found;
  logic [IW-1:0] m_idx, f_idx, v_idx;
  logic [31:0]   v_stamp;
  logic [4:0]    cnt;
  logic [30:0]   held, saved;
  logic          old_else, new_else;

  assign sts.last = (idx == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_bytes <= 12'd192;
      walk_bytes <= 16'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAG:  tag_bytes <= cfg_data[11:0];
        CFG_WALK: walk_bytes <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pass one: lookup, first free, LRU victim, stats
  logic        earlier;
  logic [30:0] held_add, saved_add, held_sum, saved_sum;
  always_comb begin
    earlier = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (IW'(j) < idx && used[j] && art_valid[j] && art_key[j] == art_key[idx] &&
          art_len[j] == art_len[idx]) earlier = 1'b1;
    end
    held_add = '0;
    saved_add = '0;
    if (used[idx]) begin
      held_add = (flags[idx][FL_TAGS] ? 31'(tag_bytes) : 31'd0) +
                 (flags[idx][FL_WALK] ? 31'(walk_bytes) : 31'd0);
      if (art_valid[idx]) begin
        if (earlier) saved_add = 31'(art_len[idx]);
        else held_add = held_add + 31'(art_len[idx]);
      end
    end
    held_sum = held + held_add;
    saved_sum = saved + saved_add;
    if (held_sum > 31'(SAT30)) held_sum = 31'(SAT30);
    if (saved_sum > 31'(SAT30)) saved_sum = 31'(SAT30);
  end

  logic [IW-1:0] s;
  logic          evict_w, allpin_w;
  assign s = m_found ? m_idx : (f_found ? f_idx : v_idx);
  assign evict_w = !m_found && !f_found && v_found;
  assign allpin_w = !m_found && !f_found && !v_found;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      pkey_q <= path_key;
      ckey_q <= content_key;
      clen_q <= content_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      m_found <= 1'b0;
      f_found <= 1'b0;
      v_found <= 1'b0;
    end else if (cmd.load) begin
      idx <= '0;
      m_found <= 1'b0;
      f_found <= 1'b0;
      v_found <= 1'b0;
      cnt <= '0;
      held <= '0;
      saved <= '0;
      old_else <= 1'b0;
      new_else <= 1'b0;
    end else if (cmd.step1) begin
      idx <= sts.last ? '0 : idx + IW'(1);
      if (used[idx] && ekey[idx] == pkey_q && !m_found) begin
        m_found <= 1'b1;
        m_idx <= idx;
      end
      if (!used[idx] && !f_found) begin
        f_found <= 1'b1;
        f_idx <= idx;
      end
      if (!pinned[idx] && (!v_found || stamp[idx] < v_stamp)) begin
        v_found <= 1'b1;
        v_idx <= idx;
        v_stamp <= stamp[idx];
      end
      if (used[idx]) cnt <= cnt + 5'd1;
      held <= held_sum;
      saved <= saved_sum;
    end else if (cmd.step2) begin
      idx <= sts.last ? '0 : idx + IW'(1);
      if (idx != s && used[idx] && art_valid[idx]) begin
        if (art_key[idx] == art_key[s] && art_len[idx] == art_len[s]) old_else <= 1'b1;
        if (art_key[idx] == ckey_q && art_len[idx] == clen_q) new_else <= 1'b1;
      end
    end
  end

  logic  is_put, put_ign, mine, new_cover, freed, hit;
  logic [31:0] clk_inc;
  res_t  res_w;
  assign clk_inc = use_clock + 32'd1;

  always_comb begin
    is_put = kind_q <= K_PUT_WALK;
    put_ign = (kind_q == K_PUT_ART) && (clen_q == 24'd0);
    mine = !evict_w && art_valid[s] && art_key[s] == ckey_q && art_len[s] == clen_q;
    new_cover = (kind_q == K_PUT_ART) && !mine;
    freed = (evict_w || new_cover) && art_valid[s] && !old_else;
    hit = 1'b0;
    if (m_found) begin
      priority case (kind_q)
        K_GET_ART, K_GET_AKEY: hit = art_valid[m_idx];
        K_GET_TAGS: hit = flags[m_idx][FL_TAGS];
        K_GET_WALK: hit = flags[m_idx][FL_WALK];
        K_Q_NOART:  hit = flags[m_idx][FL_NOART];
        default:    hit = 1'b1;
      endcase
    end
    res_w = '0;
    if (is_put) begin
      if (put_ign) res_w.status = ST_IGN;
      else if (allpin_w) res_w.status = ST_NC;
      else begin
        res_w.status = ST_DONE;
        res_w.slot = 4'(s);
        res_w.evicted = evict_w;
        res_w.shared = new_cover && new_else;
        res_w.freed_valid = freed;
        res_w.freed_key = freed ? art_key[s] : 32'd0;
      end
    end else if (kind_q <= K_PIN) begin
      if (!hit) res_w.status = ST_MISS;
      else begin
        res_w.slot = 4'(m_idx);
        if (kind_q == K_GET_ART || kind_q == K_GET_AKEY) res_w.art_key_out = art_key[m_idx];
        if (kind_q == K_GET_ART) res_w.art_len_out = art_len[m_idx];
      end
    end else if (kind_q == K_STATS) begin
      res_w.entry_count = cnt;
      res_w.bytes_held = held[29:0];
      res_w.bytes_saved = saved[29:0];
    end else if (kind_q != K_UNPIN_ALL && kind_q != K_CLEAR) begin
      res_w.status = ST_IGN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) res <= res_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] <= 1'b0;
        pinned[i] <= 1'b0;
        stamp[i] <= '0;
        ekey[i] <= '0;
        art_valid[i] <= 1'b0;
        art_key[i] <= '0;
        art_len[i] <= '0;
        flags[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (is_put) begin
        if (!put_ign && !allpin_w) begin
          logic [2:0] fb;
          fb = evict_w ? 3'd0 : flags[s];
          if (evict_w) pinned[s] <= 1'b0;
          used[s] <= 1'b1;
          ekey[s] <= pkey_q;
          if (new_cover) begin
            art_valid[s] <= 1'b1;
            art_key[s] <= ckey_q;
            art_len[s] <= clen_q;
          end else if (evict_w) begin
            art_valid[s] <= 1'b0;
            art_key[s] <= '0;
            art_len[s] <= '0;
          end
          unique case (kind_q)
            K_PUT_ART:   fb[FL_NOART] = 1'b0;
            K_PUT_NOART: fb[FL_NOART] = 1'b1;
            K_PUT_TAGS:  fb[FL_TAGS] = 1'b1;
            default:     fb[FL_WALK] = 1'b1;
          endcase
          flags[s] <= fb;
          stamp[s] <= clk_inc;
          use_clock <= clk_inc;
        end
      end else if (kind_q <= K_PIN) begin
        if (hit) begin
          if (kind_q == K_PIN) pinned[m_idx] <= 1'b1;
          if (kind_q != K_Q_NOART && kind_q != K_GET_AKEY) begin
            stamp[m_idx] <= clk_inc;
            use_clock <= clk_inc;
          end
        end
      end else if (kind_q == K_UNPIN_ALL) begin
        for (int i = 0; i < ENTRIES; i++) pinned[i] <= 1'b0;
      end else if (kind_q == K_CLEAR) begin
        for (int i = 0; i < ENTRIES; i++) begin
          used[i] <= 1'b0;
          pinned[i] <= 1'b0;
          stamp[i] <= '0;
          ekey[i] <= '0;
          art_valid[i] <= 1'b0;
          art_key[i] <= '0;
          art_len[i] <= '0;
          flags[i] <= '0;
        end
      end
    end
  end

endmodule

@@ hw/rtl/lru_tag_table_with_pins.sv @@
// LRU tag table with pinning, top level: controller, datapath and channels.
// A request is processed by two scans over the entry registers and one apply step,
// then the response is held until taken; one request is handled at a time, and
// a new one is accepted only after the response is taken.
// Reset (rst, synchronous): all entries free, use clock zero, config registers to defaults.
module lru_tag_table_with_pins import ltt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ltt_req_if.sink               req,
  ltt_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;

  ltt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .sts(sts)
  );

  ltt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .kind(req.kind), .path_key(req.path_key),
    .content_key(req.content_key), .content_len(req.content_len),
    .res(res)
  );

  assign rsp.status      = res.status;
  assign rsp.slot        = res.slot;
  assign rsp.evicted     = res.evicted;
  assign rsp.art_key_out = res.art_key_out;
  assign rsp.art_len_out = res.art_len_out;
  assign rsp.shared      = res.shared;
  assign rsp.freed_valid = res.freed_valid;
  assign rsp.freed_key   = res.freed_key;
  assign rsp.entry_count = res.entry_count;
  assign rsp.bytes_held  = res.bytes_held;
  assign rsp.bytes_saved = res.bytes_saved;

endmodule

@@ hw/rtl/ltt_chk.sv @@
// Port-level checker for the tag table, bound to the top level.
// Depends on ltt_pkg and lru_tag_table_with_pins_macros.svh.
`include "lru_tag_table_with_pins_macros.svh"
module ltt_chk import ltt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [3:0] slot,
  input logic       evicted,
  input logic       freed_valid
);

  `LTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "response dropped")
  `LTT_ASSERT_IMPL(a_one_at_a_time, out_valid, !in_ready, "request taken while busy")
  `LTT_ASSERT_NEXT(a_no_early_rsp, in_valid && in_ready, !out_valid, "response too early")
  `LTT_ASSERT_IMPL(a_ign_clean, out_valid && (status == ST_IGN || status == ST_NC),
                   slot == 4'd0 && !evicted && !freed_valid, "ignored item changed state")

endmodule

bind lru_tag_table_with_pins ltt_chk u_chk (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .status(rsp.status), .slot(rsp.slot),
  .evicted(rsp.evicted), .freed_valid(rsp.freed_valid)
);
